### rtl/core/r2fft_pkg.sv
// ----------------------------------------------------------------------------
// r2fft_pkg
// shared types, codes and the twiddle table generator for the radix-2 fft
// ----------------------------------------------------------------------------
package r2fft_pkg;

	localparam int LOG2_MAX_POINTS_DEF = 10;
	localparam int CFG_DATA_W = 4;
	localparam int CFG_IDX_W = 1;
	localparam int IDX_W = 10;
	localparam int SMP_W = 16;
	localparam int COEF_W = 17;
	localparam int ACC_W = 34;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_RUN   = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INVERSE = 1'd0,
		REG_LOG2    = 1'd1
	} reg_idx_t;

	// control of the shared multiply-accumulate unit
	typedef struct packed {
		logic en;
		logic clear;
		logic sub;
	} mac_ctl_t;

	localparam longint unsigned PiQ30 = 64'd3373259426;
	localparam longint unsigned OneQ30 = 64'd1 << 30;

	// restoring long division, only evaluated while building the table
	function automatic longint unsigned udiv64(input longint unsigned num,
		input longint unsigned den);
		longint unsigned q, r;
		q = 0;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r = r - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// one twiddle word: cos in bits 15..0, sin in bits 31..16, bit-reversed order
	function automatic logic [31:0] twiddle_word(input int unsigned j, input int unsigned lg);
		longint unsigned quarter, half, r, a, x, x2, tc, ts, m;
		longint sc, ss;
		bit flip;
		logic [15:0] cw, sw;
		quarter = (64'd1 << lg) >> 2;
		half = (64'd1 << lg) >> 1;
		r = 0;
		flip = 1'b0;
		for (int b = 0; b + 1 < lg; b++)
			r |= ((longint'(j) >> b) & 64'd1) << (lg - 2 - b);
		a = r;
		if (a > quarter) begin
			a = half - a;
			flip = 1'b1;
		end
		x = (a * PiQ30 * 64'd2) >> lg;
		x2 = (x * x + (64'd1 << 29)) >> 30;
		tc = OneQ30;
		ts = x;
		sc = longint'(OneQ30);
		ss = longint'(x);
		for (longint unsigned k = 1; k < 20; k++) begin
			tc = udiv64((tc * x2) >> 30, (64'd2 * k - 64'd1) * (64'd2 * k));
			ts = udiv64((ts * x2) >> 30, (64'd2 * k) * (64'd2 * k + 64'd1));
			if (k[0]) begin
				sc -= longint'(tc);
				ss -= longint'(ts);
			end else begin
				sc += longint'(tc);
				ss += longint'(ts);
			end
		end
		if (sc < 0) sc = 0;
		if (sc > longint'(OneQ30)) sc = longint'(OneQ30);
		if (ss < 0) ss = 0;
		if (ss > longint'(OneQ30)) ss = longint'(OneQ30);
		m = (longint'(sc) * 64'd32767 + (64'd1 << 29)) >> 30;
		if (flip) m = 64'h10000 - m;
		cw = m[15:0];
		m = (longint'(ss) * 64'd32767 + (64'd1 << 29)) >> 30;
		sw = m[15:0];
		return {sw, cw};
	endfunction

endpackage

### rtl/core/r2fft_if.sv
// ----------------------------------------------------------------------------
// r2fft_if
// request and response channels of the fft engine
// ----------------------------------------------------------------------------
interface r2fft_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        operation;
	logic [9:0]        sample_index;
	logic signed [15:0] write_re;
	logic signed [15:0] write_im;
	modport source(output valid, operation, sample_index, write_re, write_im, input ready);
	modport sink(input valid, operation, sample_index, write_re, write_im, output ready);
endinterface

interface r2fft_rsp_if;
	logic              valid;
	logic              ready;
	logic signed [15:0] read_re;
	logic signed [15:0] read_im;
	modport source(output valid, read_re, read_im, input ready);
	modport sink(input valid, read_re, read_im, output ready);
endinterface

### rtl/core/r2fft_mem.sv
// ----------------------------------------------------------------------------
// r2fft_mem
// sample memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
module r2fft_mem #(
	parameter int AW = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic [31:0]   rdata_a,
	output logic [31:0]   rdata_b
);
	logic [31:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule

### rtl/core/r2fft_mac.sv
// ----------------------------------------------------------------------------
// r2fft_mac
// shared multiply-accumulate unit used for all four butterfly products
// ----------------------------------------------------------------------------
module r2fft_mac (
	input  logic                                   clk,
	input  r2fft_pkg::mac_ctl_t                    ctl,
	input  logic signed [r2fft_pkg::COEF_W-1:0]    coef,
	input  logic signed [r2fft_pkg::SMP_W-1:0]     data,
	output logic signed [r2fft_pkg::ACC_W-1:0]     acc
);
	import r2fft_pkg::*;

	logic signed [COEF_W+SMP_W-1:0] prod;
	logic signed [ACC_W-1:0] prod_x, base, acc_q;

	always_comb begin
		prod = coef * data;
		prod_x = ACC_W'(prod);
		base = ctl.clear ? '0 : acc_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.en)
			acc_q <= ctl.sub ? base - prod_x : base + prod_x;
	end

	assign acc = acc_q;
endmodule

### rtl/core/radix2_fixed_fft_engine.sv
// ----------------------------------------------------------------------------
// radix2_fixed_fft_engine
// in-place radix-2 q15 fft over a sample memory with a built-in twiddle rom
// ----------------------------------------------------------------------------
// write and none transactions, and a run of zero length: result registered at the accepting edge
// read: one registered memory read, then the registered result
// run: each butterfly steps through ISSUE, MUL0..MUL3, WR0 and WR1, set by the one shared
//   multiply-accumulate unit (four products) and two memory writes per butterfly
// reset clears control registers, sets inverse off and log2 to 10; the sample memory is not cleared
module radix2_fixed_fft_engine #(
	parameter int LOG2_MAX_POINTS = r2fft_pkg::LOG2_MAX_POINTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [r2fft_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [r2fft_pkg::CFG_DATA_W-1:0]  cfg_data,
	r2fft_req_if.sink                         req,
	r2fft_rsp_if.source                       rsp
);
	import r2fft_pkg::*;

	localparam int L = LOG2_MAX_POINTS;
	localparam int RomDepth = ((2**L) + 1) / 2;
	localparam int RomAw = (L > 1) ? L - 1 : 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_READ, ST_ISSUE, ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3,
		ST_WR0, ST_WR1, ST_DONE
	} state_t;

	state_t state_q;
	logic inverse_q;
	logic [CFG_DATA_W-1:0] log2_q, lg_q, h_q, lg_eff;
	logic [L-1:0] bf_q, half_bit, jj, ii, addr_p, addr_m, in_idx, raddr_a;
	logic [L:0] npts;
	logic last_bf, out_free, accept, out_load;
	logic out_valid_q;
	logic signed [SMP_W-1:0] out_re_q, out_im_q;

	logic [31:0] rom [RomDepth];
	logic [31:0] rom_q, rd_a, rd_b, wdata;
	logic we;
	logic [L-1:0] waddr;

	mac_ctl_t mac_ctl;
	logic signed [COEF_W-1:0] coef, c_w, s_w;
	logic signed [SMP_W-1:0] mac_data;
	logic signed [ACC_W-1:0] acc, tre_q, bre, bim, t_re, t_im, y_re, y_im;

	for (genvar g = 0; g < RomDepth; g++) begin : g_rom
		localparam logic [31:0] TwWord = twiddle_word(g, L);
		assign rom[g] = TwWord;
	end

	// butterfly addressing for stage half = 2^h
	always_comb begin
		npts = (L+1)'(1) << lg_q;
		last_bf = (bf_q == L'((npts >> 1) - (L+1)'(1)));
		half_bit = L'(1) << h_q;
		ii = bf_q & (half_bit - L'(1));
		jj = bf_q >> h_q;
		addr_p = (jj << (h_q + CFG_DATA_W'(1))) | ii;
		addr_m = addr_p | half_bit;
		in_idx = L'(req.sample_index);
		lg_eff = (log2_q > CFG_DATA_W'(L)) ? CFG_DATA_W'(L) : log2_q;
		out_free = !out_valid_q || rsp.ready;
		req.ready = (state_q == ST_IDLE) && out_free;
		accept = req.valid && req.ready;
		// a new result is loaded into the output register this cycle
		out_load = (state_q == ST_READ) || (state_q == ST_DONE && out_free) ||
			(accept && (req.operation != OP_READ) &&
			!(req.operation == OP_RUN && lg_eff != '0));
		raddr_a = (state_q == ST_IDLE) ? in_idx : addr_p;
	end

	always_ff @(posedge clk)
		rom_q <= rom[RomAw'(jj)];

	r2fft_mem #(.AW(L)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr_a(raddr_a), .raddr_b(addr_m), .rdata_a(rd_a), .rdata_b(rd_b)
	);

	// twiddle and operand selection for the shared unit
	always_comb begin
		c_w = COEF_W'($signed(rom_q[15:0]));
		s_w = COEF_W'($signed(rom_q[31:16]));
		if (inverse_q)
			s_w = -s_w;
		mac_ctl = '0;
		coef = c_w;
		mac_data = $signed(rd_b[15:0]);
		case (state_q)
			ST_MUL0: mac_ctl = '{en: 1'b1, clear: 1'b1, sub: 1'b0};
			ST_MUL1: begin
				mac_ctl = '{en: 1'b1, clear: 1'b0, sub: 1'b0};
				coef = s_w;
				mac_data = $signed(rd_b[31:16]);
			end
			ST_MUL2: begin
				mac_ctl = '{en: 1'b1, clear: 1'b1, sub: 1'b0};
				mac_data = $signed(rd_b[31:16]);
			end
			ST_MUL3: begin
				mac_ctl = '{en: 1'b1, clear: 1'b0, sub: 1'b1};
				coef = s_w;
			end
			default: mac_ctl = '0;
		endcase
	end

	r2fft_mac u_mac (.clk(clk), .ctl(mac_ctl), .coef(coef), .data(mac_data), .acc(acc));

	always_ff @(posedge clk)
		if (state_q == ST_MUL2)
			tre_q <= acc;

	// (a*2^15 -/+ t + 2^15) >> 16, low 16 bits
	always_comb begin
		bre = (ACC_W'($signed(rd_a[15:0])) <<< 15) + ACC_W'(32768);
		bim = (ACC_W'($signed(rd_a[31:16])) <<< 15) + ACC_W'(32768);
		t_re = (state_q == ST_WR0) ? -tre_q : tre_q;
		t_im = (state_q == ST_WR0) ? -acc : acc;
		y_re = bre + t_re;
		y_im = bim + t_im;
		we = 1'b0;
		waddr = addr_p;
		wdata = {y_im[31:16], y_re[31:16]};
		case (state_q)
			ST_IDLE: begin
				we = accept && (req.operation == OP_WRITE);
				waddr = in_idx;
				wdata = {req.write_im, req.write_re};
			end
			ST_WR0: begin
				we = 1'b1;
				waddr = addr_m;
			end
			ST_WR1: we = 1'b1;
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inverse_q <= 1'b0;
			log2_q <= CFG_DATA_W'(10);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INVERSE: inverse_q <= cfg_data[0];
				REG_LOG2:    log2_q <= cfg_data;
				default:     inverse_q <= inverse_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_re_q <= '0;
			out_im_q <= '0;
			lg_q <= '0;
			h_q <= '0;
			bf_q <= '0;
		end else begin
			if (rsp.ready && !out_load)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.operation == OP_READ) begin
							state_q <= ST_READ;
						end else if (req.operation == OP_RUN && lg_eff != '0) begin
							state_q <= ST_ISSUE;
							lg_q <= lg_eff;
							h_q <= lg_eff - CFG_DATA_W'(1);
							bf_q <= '0;
						end else begin
							out_valid_q <= 1'b1;
							out_re_q <= '0;
							out_im_q <= '0;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
					out_valid_q <= 1'b1;
					out_re_q <= $signed(rd_a[15:0]);
					out_im_q <= $signed(rd_a[31:16]);
				end
				ST_ISSUE: state_q <= ST_MUL0;
				ST_MUL0:  state_q <= ST_MUL1;
				ST_MUL1:  state_q <= ST_MUL2;
				ST_MUL2:  state_q <= ST_MUL3;
				ST_MUL3:  state_q <= ST_WR0;
				ST_WR0:   state_q <= ST_WR1;
				ST_WR1: begin
					if (!last_bf) begin
						bf_q <= bf_q + L'(1);
						state_q <= ST_ISSUE;
					end else if (h_q != '0) begin
						bf_q <= '0;
						h_q <= h_q - CFG_DATA_W'(1);
						state_q <= ST_ISSUE;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						out_valid_q <= 1'b1;
						out_re_q <= '0;
						out_im_q <= '0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.read_re = out_re_q;
	assign rsp.read_im = out_im_q;

	// once a transform starts, the input is no longer ready
	a_run_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.operation == OP_RUN && lg_eff != '0) |=> !req.ready)
		else $error("input taken while transform starts");

	// the two legs of a butterfly never alias
	a_legs_differ: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR0 || state_q == ST_WR1) |-> addr_p != addr_m)
		else $error("butterfly legs alias");

	// each butterfly writes both legs in back-to-back cycles
	a_wr_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR0) |=> state_q == ST_WR1)
		else $error("butterfly write pair broken");

	// no sample write from the input side while the transform owns the memory
	a_no_input_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !accept)
		else $error("input accepted while busy");
endmodule

### sim/fft_checker.sv
// ----------------------------------------------------------------------------
// fft_checker
// predicts read-back samples of the fft engine and compares each response
// ----------------------------------------------------------------------------
module fft_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	r2fft_req_if        req,
	r2fft_rsp_if        rsp,
	output int          fail_count,
	output int          pending,
	output int          read_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import r2fft_pkg::*;

	logic [31:0] sample_mem [1024];
	logic [31:0] twiddle [512];
	logic        inv_mode;
	logic [3:0]  lg_points;
	logic [31:0] expected_q [$];

	initial begin
		for (int j = 0; j < 512; j++)
			twiddle[j] = twiddle_word(j, 10);
	end

	function automatic logic [15:0] shr_low(longint t);
		longint q;
		q = t >>> 16;
		return q[15:0];
	endfunction

	task automatic transform();
		int lg, n, ie, ia, half, m, p;
		longint c, s, mre, mim, are, aim, tre, tim, bre, bim;
		lg = (lg_points > 10) ? 10 : lg_points;
		n = 1 << lg;
		ie = 1;
		for (half = n >> 1; half > 0; half >>= 1) begin
			ia = 0;
			for (int j = 0; j < ie && j < 512; j++) begin
				c = longint'($signed(twiddle[j][15:0]));
				s = longint'($signed(twiddle[j][31:16]));
				if (inv_mode) s = -s;
				for (int i = 0; i < half; i++) begin
					m = (ia + half) & 1023;
					p = ia & 1023;
					mre = longint'($signed(sample_mem[m][15:0]));
					mim = longint'($signed(sample_mem[m][31:16]));
					are = longint'($signed(sample_mem[p][15:0]));
					aim = longint'($signed(sample_mem[p][31:16]));
					tre = c * mre + s * mim;
					tim = c * mim - s * mre;
					bre = are * 32768 + 32768;
					bim = aim * 32768 + 32768;
					sample_mem[m] = {shr_low(bim - tim), shr_low(bre - tre)};
					sample_mem[p] = {shr_low(bim + tim), shr_low(bre + tre)};
					ia++;
				end
				ia += half;
			end
			ie <<= 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_mode <= 1'b0;
			lg_points <= 4'd10;
			fail_count <= 0;
			read_count <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_INVERSE) inv_mode <= cfg_data[0];
				else lg_points <= cfg_data;
			end
			if (req.valid && req.ready) begin
				case (op_t'(req.operation))
					OP_WRITE: sample_mem[req.sample_index] = {req.write_im, req.write_re};
					OP_READ: expected_q.push_back(sample_mem[req.sample_index]);
					OP_RUN: begin
						transform();
						expected_q.push_back(32'd0);
					end
					default: expected_q.push_back(32'd0);
				endcase
				if (op_t'(req.operation) == OP_WRITE) expected_q.push_back(32'd0);
			end
			if (rsp.valid && rsp.ready) begin
				read_count <= read_count + 1;
				if (expected_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected response re=%0d im=%0d", rsp.read_re, rsp.read_im);
					fail_count <= fail_count + 1;
				end else begin
					logic [31:0] want;
					want = expected_q.pop_front();
					if (want != {rsp.read_im, rsp.read_re}) begin
						if (fail_count < 10)
							$display("mismatch: expected re=%0d im=%0d, got re=%0d im=%0d",
								$signed(want[15:0]), $signed(want[31:16]),
								rsp.read_re, rsp.read_im);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

	assign pending = expected_q.size();
endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus for the fft engine: sample loads, transforms in several lengths and
// directions, read-back of the loaded points; verdict from the checker's count
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import r2fft_pkg::*;

	localparam int WATCHDOG = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int fail_count, pending, read_count;
	int idle_cycles = 0;
	int sent = 0;
	int transforms = 0;
	bit quiet_stretch = 1'b0;

	r2fft_req_if req ();
	r2fft_rsp_if rsp ();

	radix2_fixed_fft_engine u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req), .rsp(rsp)
	);

	fft_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req), .rsp(rsp), .fail_count(fail_count),
		.pending(pending), .read_count(read_count)
	);

	always #5 clk = ~clk;

	initial begin
		req.valid = 1'b0;
		req.operation = OP_NONE;
		req.sample_index = '0;
		req.write_re = '0;
		req.write_im = '0;
		rsp.ready = 1'b0;
	end

	// response side stalls at random, except during the quiet stretch
	always @(posedge clk) begin
		rsp.ready <= quiet_stretch ? 1'b1 : ($urandom_range(99) >= 18);
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// valid stays high after a transaction until the next idle or wait
	task automatic send(op_t op, int idx, logic [15:0] re, logic [15:0] im);
		while (!quiet_stretch && $urandom_range(99) < 18) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.operation <= op;
		req.sample_index <= idx[9:0];
		req.write_re <= re;
		req.write_im <= im;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		sent++;
		if (op == OP_RUN) transforms++;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t r, logic [3:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// load the first points, transform, read them all back
	task automatic frame(int npts, bit extreme);
		logic [15:0] re, im;
		for (int i = 0; i < npts; i++) begin
			re = extreme ? (i[0] ? 16'h8000 : 16'h7fff) : 16'($urandom());
			im = extreme ? (i[1] ? 16'h7fff : 16'h8000) : 16'($urandom());
			send(OP_WRITE, i, re, im);
		end
		send(OP_RUN, $urandom_range(1023), 16'($urandom()), 16'($urandom()));
		for (int i = 0; i < npts; i++) send(OP_READ, i, 16'($urandom()), 16'($urandom()));
	endtask

	initial begin
		int lg, n;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: the low 256 entries written once so nothing unwritten is ever read
		quiet_stretch = 1'b1;
		for (int i = 0; i < 256; i++)
			send(OP_WRITE, i, 16'($urandom()), 16'($urandom()));
		send(OP_READ, 255, '0, '0);
		send(OP_NONE, 5, 16'h7fff, 16'h8000);
		send(OP_WRITE, 3, 16'h8000, 16'h7fff);
		send(OP_READ, 3, '0, '0);
		write_reg(REG_LOG2, 4'd1);
		frame(2, 1'b1);
		write_reg(REG_LOG2, 4'd0);
		frame(1, 1'b0);
		quiet_stretch = 1'b0;
		write_reg(REG_INVERSE, 4'd1);
		write_reg(REG_LOG2, 4'd3);
		frame(8, 1'b1);
		// random frames, mostly short lengths, all within the written entries
		while (sent < 870) begin
			lg = ($urandom_range(9) == 0) ? $urandom_range(8, 6) : $urandom_range(5, 1);
			n = 1 << lg;
			write_reg(REG_INVERSE, 4'($urandom_range(1)));
			write_reg(REG_LOG2, lg[3:0]);
			frame(n > 32 ? 32 : n, $urandom_range(7) == 0);
			for (int k = 0; k < 6; k++) begin
				case ($urandom_range(3))
					0: send(OP_WRITE, $urandom_range(255), 16'($urandom()), 16'($urandom()));
					1: send(OP_NONE, $urandom(), 16'($urandom()), 16'($urandom()));
					default: send(OP_READ, $urandom_range(255), 16'($urandom()),
						16'($urandom()));
				endcase
			end
		end
		write_reg(REG_LOG2, 4'd8);
		write_reg(REG_INVERSE, 4'd0);
		send(OP_RUN, 0, '0, '0);
		send(OP_READ, 1, '0, '0);
		drain();
		repeat (20) @(posedge clk);
		$display("sent %0d requests with %0d transforms, checked %0d responses",
			sent, transforms, read_count);
		if (fail_count == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule
